FILE: src/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared widths, register indexes and controller types for the spiral scan
// position locator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssl_pkg;

  // Field widths
  localparam int unsigned DIM_W     = 11;  // grid dimension, column and row
  localparam int unsigned IDX_W     = 21;  // spiral position
  localparam int unsigned AREA_W    = 2 * DIM_W;  // cell count
  localparam int unsigned SUM_W     = 13;  // ring length and side offsets
  localparam int unsigned CFG_IDX_W = 1;

  // Stream data widths, padded to whole bytes
  localparam int unsigned S_DATA_W = ((IDX_W + 7) / 8) * 8;
  localparam int unsigned M_DATA_W = ((2 * DIM_W + 7) / 8) * 8;

  // Default dimension limit
  localparam int unsigned MAX_DIM_DEFAULT = 1024;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_CHECK,
    ST_RING,
    ST_PLACE,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch index and clamped dimensions
    logic calc_area;  // register the cell count
    logic set_miss;   // stage a not-found result
    logic init_ring;  // start at the outer ring
    logic step_ring;  // skip the current ring
    logic place;      // place the index on the current ring
    logic emit;       // move the staged result to the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic miss;      // index outside the grid
    logic ring_hit;  // index lies on the current ring
    logic out_free;  // output register can take a result
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: src/ssl_ctrl.sv
// ----------------------------------------------------------------------------
// ssl_ctrl
// Sequencer for one query: cell count, range check, ring skipping,
// placement on the ring and hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_ctrl
  import ssl_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  ctrl_sts_t  sts_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // Hold the current state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance through the query
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_AREA;
      end
      ST_AREA: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.miss ? ST_DONE : ST_RING;
      end
      ST_RING: begin
        if (sts_i.ring_hit) state_d = ST_PLACE;
      end
      ST_PLACE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_AREA: begin
        cmd_o.calc_area = 1'b1;
      end
      ST_CHECK: begin
        cmd_o.set_miss  = sts_i.miss;
        cmd_o.init_ring = !sts_i.miss;
      end
      ST_RING: begin
        cmd_o.step_ring = !sts_i.ring_hit;
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1;
      end
      ST_DONE: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/ssl_dpath.sv
// ----------------------------------------------------------------------------
// ssl_dpath
// Configuration registers, ring-skipping datapath, result staging and the
// output register of the spiral scan position locator.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_dpath
  import ssl_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // Configuration writes
  input  wire                  cfg_valid_i,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [DIM_W-1:0]      cfg_data_i,
  // Query index
  input  wire [IDX_W-1:0]      seat_index_i,
  // Result output
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic                 found_o,
  output logic [DIM_W-1:0]     col_number_o,
  output logic [DIM_W-1:0]     row_number_o,
  // Controller link
  input  ctrl_cmd_t            cmd_i,
  output ctrl_sts_t            sts_o
);

  localparam logic [SUM_W-1:0] MaxDim = SUM_W'(MAX_DIM);

  logic [DIM_W-1:0]  grid_cols_q, grid_rows_q;
  logic [DIM_W-1:0]  cols_clamp, rows_clamp;
  logic [IDX_W-1:0]  p_q;
  logic [DIM_W-1:0]  cols_q, rows_q;
  logic [AREA_W-1:0] area_q;
  logic [DIM_W-1:0]  w_q, h_q, k_q;
  logic [SUM_W-1:0]  wx, hx, kx, ring;
  logic [SUM_W-1:0]  pp, side1, side2, col_w, row_w;
  logic              res_found_q;
  logic [DIM_W-1:0]  res_col_q, res_row_q;
  logic              out_valid_q;
  logic              out_found_q;
  logic [DIM_W-1:0]  out_col_q, out_row_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= DIM_W'(1);
      grid_rows_q <= DIM_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GRID_COLS: grid_cols_q <= cfg_data_i;
        REG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        default:       grid_cols_q <= grid_cols_q;
      endcase
    end
  end

  // Saturate dimensions to the supported limit
  always_comb begin
    cols_clamp = ({2'b00, grid_cols_q} > MaxDim) ? MaxDim[DIM_W-1:0] : grid_cols_q;
    rows_clamp = ({2'b00, grid_rows_q} > MaxDim) ? MaxDim[DIM_W-1:0] : grid_rows_q;
  end

  // Current ring length: a single column or row is a straight line
  always_comb begin
    wx = SUM_W'(w_q);
    hx = SUM_W'(h_q);
    kx = SUM_W'(k_q);
    if (w_q == DIM_W'(1)) begin
      ring = hx;
    end else if (h_q == DIM_W'(1)) begin
      ring = wx;
    end else begin
      ring = SUM_W'({(wx + hx), 1'b0}) - SUM_W'(4);
    end
  end

  // Place the remaining index on one side of the ring
  always_comb begin
    pp    = p_q[SUM_W-1:0];
    side1 = hx + wx - SUM_W'(1);
    side2 = SUM_W'({hx, 1'b0}) + wx - SUM_W'(2);
    if (w_q == DIM_W'(1)) begin
      col_w = kx + SUM_W'(1);
      row_w = kx + pp;
    end else if (h_q == DIM_W'(1)) begin
      col_w = kx + pp;
      row_w = kx + SUM_W'(1);
    end else if (pp <= hx) begin
      // up the left column
      col_w = kx + SUM_W'(1);
      row_w = kx + pp;
    end else if (pp <= side1) begin
      // right along the top row
      col_w = kx + SUM_W'(1) + (pp - hx);
      row_w = SUM_W'(rows_q) - kx;
    end else if (pp <= side2) begin
      // down the right column
      col_w = SUM_W'(cols_q) - kx;
      row_w = SUM_W'(rows_q) - kx - (pp - side1);
    end else begin
      // left along the bottom row
      col_w = SUM_W'(cols_q) - kx - (pp - side2);
      row_w = kx + SUM_W'(1);
    end
  end

  // Capture the query, count cells and skip rings
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      p_q    <= seat_index_i;
      cols_q <= cols_clamp;
      rows_q <= rows_clamp;
    end else if (cmd_i.step_ring) begin
      p_q <= p_q - IDX_W'(ring);
    end
    if (cmd_i.calc_area) begin
      area_q <= AREA_W'(cols_q) * AREA_W'(rows_q);
    end
    if (cmd_i.init_ring) begin
      w_q <= cols_q;
      h_q <= rows_q;
      k_q <= '0;
    end else if (cmd_i.step_ring) begin
      w_q <= w_q - DIM_W'(2);
      h_q <= h_q - DIM_W'(2);
      k_q <= k_q + DIM_W'(1);
    end
  end

  // Stage the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_miss) begin
      res_found_q <= 1'b0;
      res_col_q   <= '0;
      res_row_q   <= '0;
    end else if (cmd_i.place) begin
      res_found_q <= 1'b1;
      res_col_q   <= col_w[DIM_W-1:0];
      res_row_q   <= row_w[DIM_W-1:0];
    end
  end

  // Hold the output until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_found_q <= res_found_q;
      out_col_q   <= res_col_q;
      out_row_q   <= res_row_q;
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.miss     = (p_q == '0) || (cols_q == '0) || (rows_q == '0) ||
                     ({1'b0, p_q} > area_q);
    sts_o.ring_hit = (p_q <= IDX_W'(ring));
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_found_q;
  assign col_number_o = out_col_q;
  assign row_number_o = out_row_q;

  // A new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending output");

  // A ring is skipped only when an inner ring remains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_ring |-> (w_q > DIM_W'(2) && h_q > DIM_W'(2)))
    else $error("ring skip past the innermost ring");

  // A not-found result carries zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_col_q == '0 && out_row_q == '0))
    else $error("not-found result with nonzero coordinates");

endmodule

`default_nettype wire

FILE: src/spiral_scan_position_locator.sv
// ----------------------------------------------------------------------------
// spiral_scan_position_locator
// Locates the column and row of a 1-based position on a clockwise spiral
// over a configurable grid.
// ----------------------------------------------------------------------------
// One query at a time. A query passes through the cell count, the range check,
// ring skipping (of up to about min(cols, rows) / 2 whole rings), placement
// on the ring and hand-off to the output register; an index outside the grid
// goes from the range check straight to the hand-off. The ring-skipping loop
// subtracts one ring length per cycle. The input is taken again as soon as
// the result sits in the output register, even if that result has not been
// transferred yet. Rows count from the bottom; not-found results carry zero
// coordinates. Write the grid size only while no query is in flight.
`default_nettype none

module spiral_scan_position_locator
  import ssl_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // Configuration write channel
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [DIM_W-1:0]      cfg_data_i,
  // Query stream
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire [S_DATA_W-1:0]   s_axis_tdata,   // [20:0] seat_index, rest zero
  // Result stream
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [M_DATA_W-1:0]  m_axis_tdata,   // [10:0] col_number, [21:11] row_number
  output logic                 m_axis_tuser    // found
);

  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;
  logic [DIM_W-1:0] col_number, row_number;

  assign cfg_ready_o = 1'b1;

  ssl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssl_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .seat_index_i (s_axis_tdata[IDX_W-1:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .found_o      (m_axis_tuser),
    .col_number_o (col_number),
    .row_number_o (row_number),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  // Pack the result, zero padding on top
  assign m_axis_tdata = M_DATA_W'({row_number, col_number});

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the spiral scan position locator. Queries go out on
// the input stream in random bursts and every result is compared, field by
// field, with a locally computed spiral position. The grid size is rewritten
// between phases, once every pending result has arrived, so the run covers
// the reset grid, zero, single-line, small, odd, saturated and full grids.
// ----------------------------------------------------------------------------

module tb_top;
  import ssl_pkg::*;

  localparam int unsigned DIM_LIMIT  = MAX_DIM_DEFAULT;
  localparam int unsigned SEAT_MAX   = (1 << IDX_W) - 1;
  localparam int unsigned RANDOM_QTY = 900;
  localparam int unsigned SETTLE_CYC = 600;

  typedef struct packed {
    logic             found;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
  } seat_loc_t;

  // DUT connections; the inputs are known from time zero
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = REG_GRID_COLS;
  logic [DIM_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;

  // Grid copy kept in step with the register writes
  logic [DIM_W-1:0] grid_cols_m = 11'd1;
  logic [DIM_W-1:0] grid_rows_m = 11'd1;

  logic [IDX_W-1:0] seat_q[$];    // queries waiting for the driver
  seat_loc_t        due_locs[$];  // locations owed by the block, oldest first

  int unsigned seats_queued    = 0;
  int unsigned seats_taken     = 0;
  int unsigned locs_checked    = 0;
  int unsigned misses_seen     = 0;
  int unsigned grids_used      = 0;
  int unsigned mismatches      = 0;
  int unsigned burst_left      = 1;
  int unsigned gap_left        = 0;
  int unsigned rx_mode         = 0;
  int unsigned rx_tick         = 0;
  int unsigned hold_left       = 0;
  int unsigned long_holds_req  = 0;
  int unsigned long_holds_done = 0;

  spiral_scan_position_locator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Walk the spiral ring by ring, then place the leftover on one side
  function automatic seat_loc_t locate_seat(input logic [IDX_W-1:0] seat);
    int unsigned c, r, p, k, w, h, ring_len;
    seat_loc_t   loc;
    c   = (grid_cols_m > DIM_LIMIT) ? DIM_LIMIT : grid_cols_m;
    r   = (grid_rows_m > DIM_LIMIT) ? DIM_LIMIT : grid_rows_m;
    p   = seat;
    k   = 0;
    loc = '0;
    if (p == 0 || c == 0 || r == 0 || p > c * r) return loc;
    forever begin
      w        = c - 2 * k;
      h        = r - 2 * k;
      ring_len = (w == 1 || h == 1) ? w * h : 2 * (w + h) - 4;
      if (p <= ring_len) break;
      p -= ring_len;
      k++;
    end
    loc.found = 1'b1;
    if (w == 1) begin
      loc.col = DIM_W'(k + 1);
      loc.row = DIM_W'(k + p);
    end else if (h == 1) begin
      loc.col = DIM_W'(k + p);
      loc.row = DIM_W'(k + 1);
    end else if (p <= h) begin
      loc.col = DIM_W'(k + 1);
      loc.row = DIM_W'(k + p);
    end else if (p <= h + w - 1) begin
      loc.col = DIM_W'(k + 1 + (p - h));
      loc.row = DIM_W'(r - k);
    end else if (p <= 2 * h + w - 2) begin
      loc.col = DIM_W'(c - k);
      loc.row = DIM_W'((r - k) - (p - (h + w - 1)));
    end else begin
      loc.col = DIM_W'((c - k) - (p - (2 * h + w - 2)));
      loc.row = DIM_W'(k + 1);
    end
    return loc;
  endfunction

  // Query driver: bursts of random length with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_locs.push_back(locate_seat(s_axis_tdata[IDX_W-1:0]));
        seats_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (seat_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(S_DATA_W - IDX_W){1'b0}}, seat_q.pop_front()};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transfer, then pick the next ready level
  always @(posedge clk_i) begin
    seat_loc_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_locs.size() == 0) begin
          $error("result with no query pending: found %0d col %0d row %0d",
                 m_axis_tuser, m_axis_tdata[DIM_W-1:0], m_axis_tdata[2*DIM_W-1:DIM_W]);
          mismatches++;
        end else begin
          want = due_locs.pop_front();
          locs_checked++;
          if (!m_axis_tuser) misses_seen++;
          if (m_axis_tuser !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tdata[DIM_W-1:0] !== want.col) begin
            $error("col_number: expected %0d, got %0d", want.col, m_axis_tdata[DIM_W-1:0]);
            mismatches++;
          end
          if (m_axis_tdata[2*DIM_W-1:DIM_W] !== want.row) begin
            $error("row_number: expected %0d, got %0d",
                   want.row, m_axis_tdata[2*DIM_W-1:DIM_W]);
            mismatches++;
          end
        end
      end
      rx_tick++;
      if (long_holds_done != long_holds_req) begin
        long_holds_done++;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ((rx_tick % 8) < 5);
        endcase
      end
    end
  end

  // Write one register while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [DIM_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (sel == REG_GRID_COLS) grid_cols_m = value;
    else grid_rows_m = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
    write_reg(REG_GRID_COLS, cols);
    write_reg(REG_GRID_ROWS, rows);
    grids_used++;
  endtask

  task automatic offer(input int unsigned seat);
    seat_q.push_back(IDX_W'(seat));
    seats_queued++;
  endtask

  // Hold until every query has been taken and every location has come back
  task automatic drain();
    while (seats_taken != seats_queued || due_locs.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 11'd1;
      2:       return 11'd2047;
      3:       return 11'd1024;
      4:       return DIM_W'($urandom_range(1025, 2047));
      5:       return DIM_W'($urandom_range(1, 1024));
      default: return DIM_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic int unsigned pick_seat(input int unsigned area);
    int unsigned v;
    v = $urandom_range(0, 9);
    if (area == 0 || v == 0) return $urandom_range(0, SEAT_MAX);
    if (v == 1) return area + $urandom_range(1, 3);
    if (v == 2) return ($urandom_range(0, 1) != 0) ? area : 1;
    return $urandom_range(1, area);
  endfunction

  // Stimulus sequencer
  initial begin
    int unsigned random_sent, phase_n, c, r, area, qty;
    random_sent = 0;
    phase_n     = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset grid is a single cell; zero is never a valid position
    offer(1); offer(2); offer(0);
    drain();
    // Single column runs upward
    rx_mode = 1;
    set_grid(11'd1, 11'd5);
    offer(1); offer(5); offer(6);
    drain();
    // Single row runs rightward
    set_grid(11'd6, 11'd1);
    offer(1); offer(6); offer(7);
    drain();
    // Zero dimension holds no cells
    rx_mode = 0;
    set_grid(11'd0, 11'd4);
    offer(1);
    drain();
    set_grid(11'd4, 11'd0);
    offer(1);
    drain();
    // Side corners and the inner single-line ring
    set_grid(11'd4, 11'd3);
    offer(3); offer(4); offer(6); offer(8); offer(10); offer(11);
    drain();
    // Oversized dimensions saturate; last cell, beyond, top of the index range
    rx_mode = 3;
    set_grid(11'd2047, 11'd2047);
    offer(1); offer(1048576); offer(1048577); offer(SEAT_MAX); offer(524288); offer(0);
    drain();

    // Random phases: new grid, a batch of queries, then a full drain
    while (random_sent < RANDOM_QTY) begin
      set_grid(pick_dim(), pick_dim());
      c    = (grid_cols_m > DIM_LIMIT) ? DIM_LIMIT : grid_cols_m;
      r    = (grid_rows_m > DIM_LIMIT) ? DIM_LIMIT : grid_rows_m;
      area = c * r;
      // deep grids are slow, so keep those batches short
      qty  = (((c < r) ? c : r) > 120) ? $urandom_range(4, 10) : $urandom_range(20, 70);
      rx_mode = $urandom_range(0, 3);
      for (int unsigned i = 0; i < qty; i++) offer(pick_seat(area));
      random_sent += qty;
      if (phase_n % 6 == 1) long_holds_req++;
      phase_n++;
      drain();
    end

    repeat (SETTLE_CYC) @(posedge clk_i);
    $display("Checked %0d spiral lookups over %0d grid sizes, %0d of them off the grid.",
             locs_checked, grids_used, misses_seen);
    $display("Grids ranged from empty and single-line to saturated 1024 by 1024.");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50000000;
    $display("tb: failure");
    $finish;
  end

endmodule
